### sv/lfu_pkg.sv
// Shared types and constants for the LFU cache table.
// Used by the entry cell and the top level; depends on nothing else.
package lfu_pkg;

	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int CNT_W   = 32;
	localparam int STAMP_W = 64;
	localparam int CAP_W   = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	localparam int IX_HIT  = 0;
	localparam int IX_VIC  = 1;
	localparam int IX_FREE = 2;
	localparam int IX_N    = 3;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_TOUCH,
		OP_FILL
	} op_t;

	typedef struct packed {
		logic               valid;
		logic [KEY_W-1:0]   key;
		logic               hit;
		logic [VAL_W-1:0]   hit_value;
		logic               vic_ok;
		logic [CNT_W-1:0]   vic_count;
		logic [STAMP_W-1:0] vic_stamp;
		logic [KEY_W-1:0]   vic_key;
		logic               free_ok;
	} scan_t;

	typedef struct packed {
		op_t                op;
		logic               set_value;
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   value;
		logic [STAMP_W-1:0] stamp;
	} cmd_t;

endpackage

### sv/lfu_cell.sv
// One cache entry of the LFU table with its stage of the lookup chain.
// Depends on lfu_pkg for the scan token and write command types.
module lfu_cell import lfu_pkg::*; #(
	parameter int IW  = 4,
	parameter int IDX = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  scan_t                    prev_tok,
	input  logic [IX_N-1:0][IW-1:0]  prev_ix,
	input  cmd_t                     cmd,
	input  logic [IW-1:0]            cmd_idx,
	output scan_t                    next_tok,
	output logic [IX_N-1:0][IW-1:0]  next_ix
);

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic               valid_q;
	logic [KEY_W-1:0]   key_q;
	logic [VAL_W-1:0]   value_q;
	logic [CNT_W-1:0]   count_q;
	logic [STAMP_W-1:0] stamp_q;

	scan_t                   tok_d;
	logic [IX_N-1:0][IW-1:0] ix_d;
	scan_t                   tok_q;
	logic [IX_N-1:0][IW-1:0] ix_q;
	logic                    sel;

	always_comb begin
		tok_d = prev_tok;
		ix_d  = prev_ix;
		if (!prev_tok.hit && valid_q && key_q == prev_tok.key) begin
			tok_d.hit       = 1'b1;
			tok_d.hit_value = value_q;
			ix_d[IX_HIT]    = MY_IDX;
		end
		if (valid_q && (!prev_tok.vic_ok || count_q < prev_tok.vic_count ||
			(count_q == prev_tok.vic_count && stamp_q < prev_tok.vic_stamp))) begin
			tok_d.vic_ok    = 1'b1;
			tok_d.vic_count = count_q;
			tok_d.vic_stamp = stamp_q;
			tok_d.vic_key   = key_q;
			ix_d[IX_VIC]    = MY_IDX;
		end
		if (!prev_tok.free_ok && !valid_q) begin
			tok_d.free_ok = 1'b1;
			ix_d[IX_FREE] = MY_IDX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		ix_q <= ix_d;
	end

	assign next_tok = tok_q;
	assign next_ix  = ix_q;
	assign sel      = (cmd_idx == MY_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sel && cmd.op == OP_FILL) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sel) begin
			case (cmd.op)
				OP_TOUCH: begin
					if (count_q != '1) begin
						count_q <= count_q + CNT_W'(1);
					end
					stamp_q <= cmd.stamp;
					if (cmd.set_value) begin
						value_q <= cmd.value;
					end
				end
				OP_FILL: begin
					key_q   <= cmd.key;
					value_q <= cmd.value;
					count_q <= CNT_W'(1);
					stamp_q <= cmd.stamp;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### sv/lfu_cache_table.sv
// An accepted transaction's lookup token walks the chain of entry cells one cell per cycle,
// is captured at the end of the chain, and then the single write-back and the registered
// result follow once the output is not stalled; no new transaction is accepted until then.
// Reset empties the table, clears the touch stamp and sets capacity to 16.
// A result waiting on the output does not block acceptance of the next transaction.
module lfu_cache_table import lfu_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CAP_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    action,
	input  logic signed [KEY_W-1:0] key,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    hit,
	output logic signed [VAL_W-1:0] read_value,
	output logic                    evicted,
	output logic signed [KEY_W-1:0] evicted_key
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OW = $clog2(ENTRIES + 1);
	localparam int CW = (OW > CAP_W) ? OW : CAP_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESOLVE
	} state_t;

	state_t             state_q;
	logic [CAP_W-1:0]   cap_q;
	logic [OW-1:0]      occ_q;
	logic [STAMP_W-1:0] touch_q;
	logic               action_q;
	logic [VAL_W-1:0]   value_q;
	scan_t              fin_q;
	logic [IX_N-1:0][IW-1:0] fin_ix_q;

	logic               out_valid_q;
	logic               hit_q;
	logic [VAL_W-1:0]   read_value_q;
	logic               evicted_q;
	logic [KEY_W-1:0]   evicted_key_q;

	scan_t                   tok [ENTRIES+1];
	logic [IX_N-1:0][IW-1:0] tix [ENTRIES+1];

	cmd_t               cmd;
	logic [IW-1:0]      cmd_idx;
	logic               go;
	logic               accept;
	logic [CW-1:0]      eff_cap;
	logic               full;
	logic [STAMP_W-1:0] new_stamp;
	logic               r_hit;
	logic [VAL_W-1:0]   r_rd;
	logic               r_ev;
	logic [KEY_W-1:0]   r_evk;
	logic               occ_inc;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign go        = (state_q == ST_RESOLVE) && (!out_valid_q || !out_stall);

	assign tok[0] = '{valid: accept, key: key, default: '0};
	assign tix[0] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lfu_cell #(
			.IW  (IW),
			.IDX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.prev_tok (tok[i]),
			.prev_ix  (tix[i]),
			.cmd      (cmd),
			.cmd_idx  (cmd_idx),
			.next_tok (tok[i+1]),
			.next_ix  (tix[i+1])
		);
	end

	always_comb begin
		cmd           = '0;
		cmd.op        = OP_NONE;
		cmd.key       = fin_q.key;
		cmd.value     = value_q;
		cmd_idx       = '0;
		r_hit         = 1'b0;
		r_rd          = '0;
		r_ev          = 1'b0;
		r_evk         = '0;
		occ_inc       = 1'b0;
		eff_cap       = (CW'(cap_q) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(cap_q);
		full          = (CW'(occ_q) >= eff_cap);
		new_stamp     = touch_q + STAMP_W'(1);
		cmd.stamp     = new_stamp;
		if (fin_q.hit) begin
			r_hit   = 1'b1;
			cmd.op  = OP_TOUCH;
			cmd_idx = fin_ix_q[IX_HIT];
			if (action_q == ACT_PUT) begin
				cmd.set_value = 1'b1;
			end else begin
				r_rd = fin_q.hit_value;
			end
		end else if (action_q == ACT_GET) begin
			r_rd = '1;
		end else if (eff_cap != '0) begin
			if (full && fin_q.vic_ok) begin
				r_ev    = 1'b1;
				r_evk   = fin_q.vic_key;
				cmd.op  = OP_FILL;
				cmd_idx = fin_ix_q[IX_VIC];
			end else if (fin_q.free_ok) begin
				cmd.op  = OP_FILL;
				cmd_idx = fin_ix_q[IX_FREE];
				occ_inc = 1'b1;
			end
		end
		if (!go) begin
			cmd.op = OP_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cap_q         <= CAP_RESET;
			occ_q         <= '0;
			touch_q       <= '0;
			action_q      <= ACT_GET;
			value_q       <= '0;
			fin_q         <= '0;
			fin_ix_q      <= '0;
			out_valid_q   <= 1'b0;
			hit_q         <= 1'b0;
			read_value_q  <= '0;
			evicted_q     <= 1'b0;
			evicted_key_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (out_valid_q && !out_stall && !go) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						action_q <= action;
						value_q  <= value;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tok[ENTRIES].valid) begin
						fin_q    <= tok[ENTRIES];
						fin_ix_q <= tix[ENTRIES];
						state_q  <= ST_RESOLVE;
					end
				end
				ST_RESOLVE: begin
					if (go) begin
						out_valid_q   <= 1'b1;
						hit_q         <= r_hit;
						read_value_q  <= r_rd;
						evicted_q     <= r_ev;
						evicted_key_q <= r_evk;
						if (cmd.op != OP_NONE) begin
							touch_q <= new_stamp;
						end
						if (occ_inc) begin
							occ_q <= occ_q + OW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign read_value  = read_value_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

endmodule
